FILE: src/cramer_3x3_linear_solver_unit_assert.svh
// assertion macros used by the solver checker file
`ifndef CRAMER_3X3_LINEAR_SOLVER_UNIT_ASSERT_SVH
`define CRAMER_3X3_LINEAR_SOLVER_UNIT_ASSERT_SVH

// checked only while out of reset
`define CR3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked across reset as well
`define CR3_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/cr3_pkg.sv
// constants and term tables for the 3x3 cramer solver
package cr3_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int MINOR_W    = 65;
    localparam int DET_W      = 98;
    localparam int MAG_W      = 97;
    localparam int QUO_W      = 33;
    localparam int NUM_MINORS = 6;
    localparam int NUM_TERMS  = 12;
    localparam int NUM_DETS   = 4;
    localparam int NUM_LANES  = 3;
    localparam int NUM_COLS   = 4;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    // 2x2 minors of rows 2 and 3 over column pairs, column 3 is the right-hand side
    localparam int PAIR_J [NUM_MINORS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_K [NUM_MINORS] = '{1, 2, 3, 2, 3, 3};

    // row 1 coefficient, minor and sign of each expansion term, three per determinant
    localparam int TERM_COEF  [NUM_TERMS] = '{0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3};
    localparam int TERM_MINOR [NUM_TERMS] = '{3, 1, 0, 3, 5, 4, 5, 1, 2, 4, 2, 0};
    localparam bit TERM_NEG   [NUM_TERMS] = '{0, 1, 0, 0, 0, 1, 1, 1, 0, 0, 1, 0};

endpackage

FILE: src/cramer_3x3_linear_solver_unit.sv
// 3x3 linear solver by cramer's rule, fully pipelined with restoring dividers
// throughput: one item per cycle while m_ready holds, set by one quotient bit per divider stage (33 stages)
// each stage holds its beat until the next stage frees, so bubbles close up under stall
// reset: synchronous active-low aresetn clears all stage valid bits, payload is not reset
module cramer_3x3_linear_solver_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a11,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a12,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a13,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a21,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a22,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a23,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a31,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a32,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_a33,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_b_x,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_b_y,
    input  logic signed [cr3_pkg::DATA_W-1:0] s_b_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cr3_pkg::DATA_W-1:0] m_sol_x,
    output logic signed [cr3_pkg::DATA_W-1:0] m_sol_y,
    output logic signed [cr3_pkg::DATA_W-1:0] m_sol_z,
    output logic                              m_singular,
    output logic                              m_overflow
);

    localparam int DW  = cr3_pkg::DATA_W;
    localparam int MW  = cr3_pkg::MAG_W;
    localparam int QW  = cr3_pkg::QUO_W;
    localparam int NL  = cr3_pkg::NUM_LANES;
    localparam int CW  = MW + QW + FRAC_BITS;
    localparam int DS0 = 7;
    localparam int NS  = DS0 + QW + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // stage k moves when it is empty or the stage after it moves
    assign en[NS-1] = !v_reg[NS-1] || m_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NS-1];
    assign v_next  = {v_reg[NS-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    logic signed [DW-1:0] r1 [cr3_pkg::NUM_COLS];
    logic signed [DW-1:0] r2 [cr3_pkg::NUM_COLS];
    logic signed [DW-1:0] r3 [cr3_pkg::NUM_COLS];

    assign r1 = '{s_a11, s_a12, s_a13, s_b_x};
    assign r2 = '{s_a21, s_a22, s_a23, s_b_y};
    assign r3 = '{s_a31, s_a32, s_a33, s_b_z};

    // stage 0: cross products of rows 2 and 3
    logic signed [cr3_pkg::PROD_W-1:0] pa_reg [cr3_pkg::NUM_MINORS];
    logic signed [cr3_pkg::PROD_W-1:0] pb_reg [cr3_pkg::NUM_MINORS];
    logic signed [DW-1:0]              r1_s0_reg [cr3_pkg::NUM_COLS];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int p = 0; p < cr3_pkg::NUM_MINORS; p++) begin
                pa_reg[p] <= r2[cr3_pkg::PAIR_J[p]] * r3[cr3_pkg::PAIR_K[p]];
                pb_reg[p] <= r2[cr3_pkg::PAIR_K[p]] * r3[cr3_pkg::PAIR_J[p]];
            end
            r1_s0_reg <= r1;
        end
    end

    // stage 1: 2x2 minors
    logic signed [cr3_pkg::MINOR_W-1:0] mn_reg [cr3_pkg::NUM_MINORS];
    logic signed [DW-1:0]               r1_s1_reg [cr3_pkg::NUM_COLS];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int p = 0; p < cr3_pkg::NUM_MINORS; p++) begin
                mn_reg[p] <= cr3_pkg::MINOR_W'(pa_reg[p]) - cr3_pkg::MINOR_W'(pb_reg[p]);
            end
            r1_s1_reg <= r1_s0_reg;
        end
    end

    // stage 2: coefficient times minor, split into low and high partial products
    logic signed [cr3_pkg::MINOR_W-1:0] pl_reg [cr3_pkg::NUM_TERMS];
    logic signed [cr3_pkg::MINOR_W-1:0] ph_reg [cr3_pkg::NUM_TERMS];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int t = 0; t < cr3_pkg::NUM_TERMS; t++) begin
                pl_reg[t] <= r1_s1_reg[cr3_pkg::TERM_COEF[t]]
                           * $signed({1'b0, mn_reg[cr3_pkg::TERM_MINOR[t]][DW-1:0]});
                ph_reg[t] <= r1_s1_reg[cr3_pkg::TERM_COEF[t]]
                           * $signed(mn_reg[cr3_pkg::TERM_MINOR[t]][cr3_pkg::MINOR_W-1:DW]);
            end
        end
    end

    // stage 3: recombine partial products and apply the term sign
    logic signed [cr3_pkg::DET_W-1:0] term_raw [cr3_pkg::NUM_TERMS];
    logic signed [cr3_pkg::DET_W-1:0] term_reg [cr3_pkg::NUM_TERMS];

    always_comb begin
        for (int t = 0; t < cr3_pkg::NUM_TERMS; t++) begin
            term_raw[t] = (cr3_pkg::DET_W'(ph_reg[t]) <<< DW) + cr3_pkg::DET_W'(pl_reg[t]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int t = 0; t < cr3_pkg::NUM_TERMS; t++) begin
                term_reg[t] <= cr3_pkg::TERM_NEG[t] ? -term_raw[t] : term_raw[t];
            end
        end
    end

    // stage 4: determinants, index 0 is det(A), then x, y, z numerators
    logic signed [cr3_pkg::DET_W-1:0] det_reg [cr3_pkg::NUM_DETS];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int d = 0; d < cr3_pkg::NUM_DETS; d++) begin
                det_reg[d] <= term_reg[3*d] + term_reg[3*d+1] + term_reg[3*d+2];
            end
        end
    end

    // stage 5: magnitudes and quotient signs
    logic [cr3_pkg::DET_W-1:0] abs_det [cr3_pkg::NUM_DETS];
    logic [MW-1:0]             den_s5_reg;
    logic [MW-1:0]             mag_s5_reg [NL];
    logic [NL-1:0]             neg_s5_reg;
    logic                      sing_s5_reg;

    always_comb begin
        for (int d = 0; d < cr3_pkg::NUM_DETS; d++) begin
            abs_det[d] = det_reg[d][cr3_pkg::DET_W-1] ? -det_reg[d] : det_reg[d];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            den_s5_reg  <= abs_det[0][MW-1:0];
            sing_s5_reg <= (det_reg[0] == '0);
            for (int l = 0; l < NL; l++) begin
                mag_s5_reg[l] <= abs_det[l+1][MW-1:0];
                neg_s5_reg[l] <= det_reg[l+1][cr3_pkg::DET_W-1]
                               ^ det_reg[0][cr3_pkg::DET_W-1];
            end
        end
    end

    // stage 6: scale the numerators and flag quotients of 2^33 or more
    logic [CW-1:0] rem_s6_reg [NL];
    logic [NL-1:0] pre_s6_reg;
    logic [NL-1:0] neg_s6_reg;
    logic [MW-1:0] den_s6_reg;
    logic          sing_s6_reg;

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int l = 0; l < NL; l++) begin
                rem_s6_reg[l] <= CW'(mag_s5_reg[l]) << FRAC_BITS;
                pre_s6_reg[l] <= (CW'(mag_s5_reg[l]) << FRAC_BITS) >= (CW'(den_s5_reg) << QW);
            end
            neg_s6_reg  <= neg_s5_reg;
            den_s6_reg  <= den_s5_reg;
            sing_s6_reg <= sing_s5_reg;
        end
    end

    // divider stages, one quotient bit each, msb first
    logic [CW-1:0] rem_reg  [QW][NL];
    logic [QW-1:0] q_reg    [QW][NL];
    logic [MW-1:0] den_reg  [QW];
    logic [NL-1:0] pre_reg  [QW];
    logic [NL-1:0] neg_reg  [QW];
    logic [QW-1:0] sing_reg;

    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [CW-1:0] rem_in [NL];
        logic [QW-1:0] q_in   [NL];
        logic [MW-1:0] den_in;
        logic [NL-1:0] pre_in;
        logic [NL-1:0] neg_in;
        logic          sing_in;
        logic [CW-1:0] den_sh;

        if (i == 0) begin : g_first
            assign rem_in  = rem_s6_reg;
            assign q_in    = '{default: '0};
            assign den_in  = den_s6_reg;
            assign pre_in  = pre_s6_reg;
            assign neg_in  = neg_s6_reg;
            assign sing_in = sing_s6_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign pre_in  = pre_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign sing_in = sing_reg[i-1];
        end

        assign den_sh = CW'(den_in) << (QW - 1 - i);

        always_ff @(posedge aclk) begin
            if (en[DS0+i]) begin
                for (int l = 0; l < NL; l++) begin
                    if (rem_in[l] >= den_sh) begin
                        rem_reg[i][l] <= rem_in[l] - den_sh;
                        q_reg[i][l]   <= q_in[l] | (QW'(1) << (QW - 1 - i));
                    end else begin
                        rem_reg[i][l] <= rem_in[l];
                        q_reg[i][l]   <= q_in[l];
                    end
                end
                den_reg[i]  <= den_in;
                pre_reg[i]  <= pre_in;
                neg_reg[i]  <= neg_in;
                sing_reg[i] <= sing_in;
            end
        end
    end

    // output stage: sign, saturation and the singular override
    logic [DW-1:0] sol_val [NL];
    logic [NL-1:0] sat;
    logic [QW-1:0] neg_q   [NL];
    logic [DW-1:0] sol_reg [NL];
    logic          sing_out_reg;
    logic          ovf_out_reg;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            neg_q[l] = -q_reg[QW-1][l];
            if (neg_reg[QW-1][l]) begin
                sat[l]     = pre_reg[QW-1][l] || (q_reg[QW-1][l] > {1'b0, cr3_pkg::SAT_NEG});
                sol_val[l] = sat[l] ? cr3_pkg::SAT_NEG : neg_q[l][DW-1:0];
            end else begin
                sat[l]     = pre_reg[QW-1][l] || (q_reg[QW-1][l] > {1'b0, cr3_pkg::SAT_POS});
                sol_val[l] = sat[l] ? cr3_pkg::SAT_POS : q_reg[QW-1][l][DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            sing_out_reg <= sing_reg[QW-1];
            ovf_out_reg  <= !sing_reg[QW-1] && (|sat);
            for (int l = 0; l < NL; l++) begin
                sol_reg[l] <= sing_reg[QW-1] ? '0 : sol_val[l];
            end
        end
    end

    assign m_sol_x    = sol_reg[0];
    assign m_sol_y    = sol_reg[1];
    assign m_sol_z    = sol_reg[2];
    assign m_singular = sing_out_reg;
    assign m_overflow = ovf_out_reg;

endmodule

FILE: src/cr3_checker.sv
// port-level checker for the cramer solver and its bind
`include "cramer_3x3_linear_solver_unit_assert.svh"

module cr3_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cr3_pkg::DATA_W-1:0]  m_sol_x,
    input logic [cr3_pkg::DATA_W-1:0]  m_sol_y,
    input logic [cr3_pkg::DATA_W-1:0]  m_sol_z,
    input logic                        m_singular,
    input logic                        m_overflow
);

    logic sat_x;
    logic sat_y;
    logic sat_z;
    logic sol_zero;

    assign sat_x    = (m_sol_x == cr3_pkg::SAT_POS) || (m_sol_x == cr3_pkg::SAT_NEG);
    assign sat_y    = (m_sol_y == cr3_pkg::SAT_POS) || (m_sol_y == cr3_pkg::SAT_NEG);
    assign sat_z    = (m_sol_z == cr3_pkg::SAT_POS) || (m_sol_z == cr3_pkg::SAT_NEG);
    assign sol_zero = (m_sol_x == '0) && (m_sol_y == '0) && (m_sol_z == '0);

    // a singular beat carries zero solutions and no overflow
    `CR3_ASSERT(a_singular_clean, m_valid && m_singular |-> sol_zero && !m_overflow, "singular beat not clean")

    // overflow only with at least one saturated component
    `CR3_ASSERT(a_overflow_sat, m_valid && m_overflow |-> sat_x || sat_y || sat_z, "overflow without saturation")

    // a stalled result beat stays valid and keeps m_sol_x
    `CR3_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_sol_x), "result beat dropped under stall")

    // nothing comes out right after reset
    `CR3_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid && s_ready, "pipeline not empty after reset")

endmodule

bind cramer_3x3_linear_solver_unit cr3_checker u_cr3_checker (.*);
